// File: sv/bfsc_pkg.sv
// Shared types, constants and functions for the binary frame sync / CRC block.
// Used by the interfaces, every RTL module and the checker.
package bfsc_pkg;

  localparam int unsigned LEN_W       = 17;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] PRE0 = 8'hAA;
  localparam logic [7:0] PRE1 = 8'h44;
  localparam logic [7:0] PRE2 = 8'hB5;

  localparam logic [LEN_W-1:0] HDR_LEN       = 17'd24;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd16380;
  localparam logic [31:0]      CRC_POLY      = 32'hEDB88320;
  localparam logic [7:0]       BAD_TIME_STATUS = 8'd201;

  // Message ids with a class of their own
  localparam logic [15:0] ID_CORR1   = 16'd2302;
  localparam logic [15:0] ID_CORR2   = 16'd2304;
  localparam logic [15:0] ID_CORR3   = 16'd2306;
  localparam logic [15:0] ID_CORR4   = 16'd2308;
  localparam logic [15:0] ID_GPS_EPH = 16'd106;
  localparam logic [15:0] ID_BDS_EPH = 16'd2999;

  localparam logic [2:0] CLS_CORR1   = 3'd0;
  localparam logic [2:0] CLS_CORR2   = 3'd1;
  localparam logic [2:0] CLS_CORR3   = 3'd2;
  localparam logic [2:0] CLS_CORR4   = 3'd3;
  localparam logic [2:0] CLS_GPS_EPH = 3'd4;
  localparam logic [2:0] CLS_BDS_EPH = 3'd5;
  localparam logic [2:0] CLS_OTHER   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_LEN_ERR  = 2'd2,
    ST_BAD_TIME = 2'd3
  } status_t;

  // Header field that a frame byte lands in
  typedef enum logic [3:0] {
    FLD_NONE   = 4'd0,
    FLD_ID_LO  = 4'd1,
    FLD_ID_HI  = 4'd2,
    FLD_TS     = 4'd3,
    FLD_WK_LO  = 4'd4,
    FLD_WK_HI  = 4'd5,
    FLD_TOW0   = 4'd6,
    FLD_TOW1   = 4'd7,
    FLD_TOW2   = 4'd8,
    FLD_TOW3   = 4'd9
  } fld_t;

  // One classified byte, handed from the front end to the back end
  typedef struct packed {
    logic             sof;        // preamble seen: restart crc and fields
    logic [7:0]       data;
    logic             crc_en;     // byte goes through the crc, else it is a crc byte
    logic [1:0]       rx_sh;      // byte lane of a received crc byte
    fld_t             fld;
    logic             len_err;
    logic             last;
    logic [LEN_W-1:0] frame_len;
  } op_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_PRE = crc_byte(crc_byte(crc_byte(32'd0, PRE0), PRE1), PRE2);

  function automatic logic [2:0] class_of(input logic [15:0] id);
    logic [2:0] cls;
    case (id)
      ID_CORR1:   cls = CLS_CORR1;
      ID_CORR2:   cls = CLS_CORR2;
      ID_CORR3:   cls = CLS_CORR3;
      ID_CORR4:   cls = CLS_CORR4;
      ID_GPS_EPH: cls = CLS_GPS_EPH;
      ID_BDS_EPH: cls = CLS_BDS_EPH;
      default:    cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// File: sv/bfsc_if.sv
// Valid/ready channel interfaces for the byte input and the frame result.
// Depends on bfsc_pkg for the length width.
interface bfsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface bfsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    frame_status;
  logic [15:0]                   message_id;
  logic [2:0]                    message_class;
  logic [bfsc_pkg::LEN_W-1:0]    frame_length;
  logic [7:0]                    time_status;
  logic [15:0]                   week_number;
  logic [31:0]                   tow_ms;

  modport source (output valid, output frame_status, output message_id,
                  output message_class, output frame_length, output time_status,
                  output week_number, output tow_ms, input ready);
  modport sink   (input valid, input frame_status, input message_id,
                  input message_class, input frame_length, input time_status,
                  input week_number, input tow_ms, output ready);
endinterface

// File: sv/binary_receiver_frame_sync_crc_top.sv
// Binary receiver frame synchronizer with CRC-32 check.
// Depends on bfsc_pkg, bfsc_if, bfsc_front, bfsc_queue and bfsc_back.
//
// Usage:
//   in_ch  carries received bytes, one per accepted item, valid/ready.
//   out_ch carries one result per finished or rejected frame: status, id,
//          class, length and the header time fields.
//   cfg_we/cfg_wdata write max_frame_len; write it only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The front end
//   classifies a byte in the cycle it is accepted; the back end runs one
//   byte-wide CRC step per cycle while it pops. The last CRC byte (or length
//   byte 7 on a length error) is queued, then registered with out_ch.valid.
// A queue of QUEUE_DEPTH entries sits between front and back end. When
//   out_ch stalls with a result pending, the back end keeps draining frame
//   bytes and holds only the byte that ends the next frame; the queue then
//   fills and in_ch.ready drops once QUEUE_DEPTH entries wait.
// Reset: hunting for the preamble with an empty window, queue empty, no
//   result pending, max_frame_len back to 16380. No clearing pass.
module binary_receiver_frame_sync_crc_top #(
  parameter int unsigned QUEUE_DEPTH = bfsc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bfsc_in_if.sink                    in_ch,
  bfsc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [bfsc_pkg::LEN_W-1:0] cfg_wdata
);

  logic          q_full;
  logic          push;
  logic          pop;
  logic          q_valid;
  bfsc_pkg::op_t push_op;
  bfsc_pkg::op_t q_op;

  bfsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  bfsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  bfsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_op              (q_op),
    .pop               (pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_frame_status  (out_ch.frame_status),
    .out_message_id    (out_ch.message_id),
    .out_message_class (out_ch.message_class),
    .out_frame_length  (out_ch.frame_length),
    .out_time_status   (out_ch.time_status),
    .out_week_number   (out_ch.week_number),
    .out_tow_ms        (out_ch.tow_ms)
  );

endmodule

// File: sv/bfsc_front.sv
// Front end: preamble hunt, byte counting, length check and byte classification.
// Depends on bfsc_pkg; pushes op_t entries into bfsc_queue.
module bfsc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data,
  input  logic                       cfg_we,
  input  logic [bfsc_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                       q_full,
  output logic                       push,
  output bfsc_pkg::op_t              push_op
);

  localparam int unsigned LW = bfsc_pkg::LEN_W;

  logic [23:0]   win_r, win_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] exp_r, exp_nxt;
  logic [LW-1:0] max_r;
  logic [LW-1:0] cnt_inc;
  logic          accept;
  logic          len_err;
  logic          last;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    exp_nxt = exp_r;
    len_err = 1'b0;
    last    = 1'b0;
    push    = 1'b0;
    push_op = '0;
    push_op.data = in_data;
    push_op.fld  = bfsc_pkg::FLD_NONE;

    if (cnt_r == '0) begin
      // hunting: shift the window, start a frame on the preamble
      win_nxt = {win_r[15:0], in_data};
      if (win_nxt == {bfsc_pkg::PRE0, bfsc_pkg::PRE1, bfsc_pkg::PRE2}) begin
        cnt_nxt     = LW'(3);
        exp_nxt     = '0;
        push        = accept;
        push_op.sof = 1'b1;
      end
    end else begin
      case (cnt_r)
        LW'(6):  exp_nxt = {{(LW-8){1'b0}}, in_data};
        LW'(7):  exp_nxt = {1'b0, in_data, exp_r[7:0]} + bfsc_pkg::HDR_LEN;
        default: exp_nxt = exp_r;
      endcase

      len_err = (cnt_r == LW'(7)) && (exp_nxt > max_r);
      last    = !len_err && (cnt_inc >= LW'(8))
                && ({1'b0, cnt_inc} >= ({1'b0, exp_nxt} + (LW+1)'(4)));
      cnt_nxt = (len_err || last) ? '0 : cnt_inc;

      push              = accept;
      push_op.crc_en    = (cnt_r < LW'(8)) || (cnt_r < exp_r);
      push_op.rx_sh     = cnt_r[1:0] - exp_r[1:0];
      push_op.len_err   = len_err;
      push_op.last      = last;
      push_op.frame_len = exp_nxt;

      case (cnt_r)
        LW'(4):  push_op.fld = bfsc_pkg::FLD_ID_LO;
        LW'(5):  push_op.fld = bfsc_pkg::FLD_ID_HI;
        LW'(9):  push_op.fld = bfsc_pkg::FLD_TS;
        LW'(10): push_op.fld = bfsc_pkg::FLD_WK_LO;
        LW'(11): push_op.fld = bfsc_pkg::FLD_WK_HI;
        LW'(12): push_op.fld = bfsc_pkg::FLD_TOW0;
        LW'(13): push_op.fld = bfsc_pkg::FLD_TOW1;
        LW'(14): push_op.fld = bfsc_pkg::FLD_TOW2;
        LW'(15): push_op.fld = bfsc_pkg::FLD_TOW3;
        default: push_op.fld = bfsc_pkg::FLD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
      exp_r <= '0;
      max_r <= bfsc_pkg::MAX_LEN_RESET;
    end else begin
      if (accept) begin
        win_r <= win_nxt;
        cnt_r <= cnt_nxt;
        exp_r <= exp_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

endmodule

// File: sv/bfsc_queue.sv
// Short first-in first-out queue of classified bytes between front and back end.
// Depends on bfsc_pkg for op_t.
module bfsc_queue #(
  parameter int unsigned DEPTH = bfsc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfsc_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output bfsc_pkg::op_t q_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bfsc_pkg::op_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_op    = slot_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/bfsc_back.sv
// Back end: runs the crc, collects header fields and registers the frame result.
// Depends on bfsc_pkg; pops op_t entries from bfsc_queue.
module bfsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bfsc_pkg::op_t              q_op,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_frame_status,
  output logic [15:0]                out_message_id,
  output logic [2:0]                 out_message_class,
  output logic [bfsc_pkg::LEN_W-1:0] out_frame_length,
  output logic [7:0]                 out_time_status,
  output logic [15:0]                out_week_number,
  output logic [31:0]                out_tow_ms
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  ts_r, ts_nxt;
  logic [15:0] wk_r, wk_nxt;
  logic [31:0] tow_r, tow_nxt;
  logic        emit;
  logic        valid_r, valid_nxt;

  bfsc_pkg::status_t st;

  logic [1:0]                 st_r;
  logic [15:0]                oid_r;
  logic [2:0]                 ocls_r;
  logic [bfsc_pkg::LEN_W-1:0] olen_r;
  logic [7:0]                 ots_r;
  logic [15:0]                owk_r;
  logic [31:0]                otow_r;

  assign emit = q_op.last || q_op.len_err;
  // hold a frame-ending queue head while a result waits that is not being taken
  assign pop  = q_valid && (!emit || !valid_r || out_ready);

  always_comb begin
    crc_nxt = crc_r;
    rx_nxt  = rx_r;
    id_nxt  = id_r;
    ts_nxt  = ts_r;
    wk_nxt  = wk_r;
    tow_nxt = tow_r;
    if (q_op.sof) begin
      crc_nxt = bfsc_pkg::CRC_PRE;
      rx_nxt  = '0;
      id_nxt  = '0;
      ts_nxt  = '0;
      wk_nxt  = '0;
      tow_nxt = '0;
    end else begin
      if (q_op.crc_en) begin
        crc_nxt = bfsc_pkg::crc_byte(crc_r, q_op.data);
      end else begin
        rx_nxt = rx_r | ({24'd0, q_op.data} << {q_op.rx_sh, 3'b000});
      end
      case (q_op.fld)
        bfsc_pkg::FLD_ID_LO: id_nxt[7:0]    = q_op.data;
        bfsc_pkg::FLD_ID_HI: id_nxt[15:8]   = q_op.data;
        bfsc_pkg::FLD_TS:    ts_nxt         = q_op.data;
        bfsc_pkg::FLD_WK_LO: wk_nxt[7:0]    = q_op.data;
        bfsc_pkg::FLD_WK_HI: wk_nxt[15:8]   = q_op.data;
        bfsc_pkg::FLD_TOW0:  tow_nxt[7:0]   = q_op.data;
        bfsc_pkg::FLD_TOW1:  tow_nxt[15:8]  = q_op.data;
        bfsc_pkg::FLD_TOW2:  tow_nxt[23:16] = q_op.data;
        bfsc_pkg::FLD_TOW3:  tow_nxt[31:24] = q_op.data;
        default: ;
      endcase
    end

    if (q_op.len_err) begin
      st = bfsc_pkg::ST_LEN_ERR;
    end else if (crc_r != rx_nxt) begin
      st = bfsc_pkg::ST_CRC_ERR;
    end else if ((ts_nxt == bfsc_pkg::BAD_TIME_STATUS) || (wk_nxt == '0)) begin
      st = bfsc_pkg::ST_BAD_TIME;
    end else begin
      st = bfsc_pkg::ST_OK;
    end

    if (pop && emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      crc_r <= crc_nxt;
      rx_r  <= rx_nxt;
      id_r  <= id_nxt;
      ts_r  <= ts_nxt;
      wk_r  <= wk_nxt;
      tow_r <= tow_nxt;
    end
    if (pop && emit) begin
      st_r   <= st;
      oid_r  <= id_nxt;
      ocls_r <= bfsc_pkg::class_of(id_nxt);
      olen_r <= q_op.frame_len;
      ots_r  <= ts_nxt;
      owk_r  <= wk_nxt;
      otow_r <= tow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_frame_status  = st_r;
  assign out_message_id    = oid_r;
  assign out_message_class = ocls_r;
  assign out_frame_length  = olen_r;
  assign out_time_status   = ots_r;
  assign out_week_number   = owk_r;
  assign out_tow_ms        = otow_r;

endmodule

// File: sv/bfsc_checker.sv
// Port-level checks on the frame synchronizer results, bound to the top level.
// Depends on bfsc_pkg and binary_receiver_frame_sync_crc_top.
module bfsc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_frame_status,
  input logic [15:0]                out_message_id,
  input logic [2:0]                 out_message_class,
  input logic [bfsc_pkg::LEN_W-1:0] out_frame_length,
  input logic [7:0]                 out_time_status,
  input logic [15:0]                out_week_number,
  input logic [31:0]                out_tow_ms
);

  // a stalled result holds its status, id, length and time of week
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status)
      && $stable(out_message_id) && $stable(out_tow_ms) && $stable(out_frame_length))
    else $error("result changed while stalled");

  a_len_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == bfsc_pkg::ST_LEN_ERR)
      |-> (out_time_status == '0) && (out_week_number == '0) && (out_tow_ms == '0))
    else $error("length error result carries time fields");

  a_ok_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == bfsc_pkg::ST_OK)
      |-> (out_time_status != bfsc_pkg::BAD_TIME_STATUS) && (out_week_number != '0))
    else $error("ok status with bad time");

  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_length >= bfsc_pkg::HDR_LEN)
      && (out_message_class == bfsc_pkg::class_of(out_message_id)))
    else $error("frame length below header or class mismatch");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_receiver_frame_sync_crc_top bfsc_checker u_bfsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_frame_status  (out_ch.frame_status),
  .out_message_id    (out_ch.message_id),
  .out_message_class (out_ch.message_class),
  .out_frame_length  (out_ch.frame_length),
  .out_time_status   (out_ch.time_status),
  .out_week_number   (out_ch.week_number),
  .out_tow_ms        (out_ch.tow_ms)
);

// File: tb/binary_receiver_frame_sync_crc_top_test.sv
// Self-checking bench for binary_receiver_frame_sync_crc_top: builds byte streams of
// framed messages, predicts each frame report and compares it with the result channel.
// Depends on bfsc_pkg, bfsc_if and the RTL top level.
module binary_receiver_frame_sync_crc_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfsc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    status_t          status;
    logic [15:0]      id;
    logic [2:0]       cls;
    logic [LEN_W-1:0] len;
    logic [7:0]       ts;
    logic [15:0]      wk;
    logic [31:0]      tow;
  } frame_rpt_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  bfsc_in_if  in_ch();
  bfsc_out_if out_ch();

  binary_receiver_frame_sync_crc_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  logic [7:0]  tx_bytes[$];
  frame_rpt_t  pending_reports[$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int          src_gap_pct  = 0;
  int          sink_stall_pct = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;

  logic [15:0] known_ids [6] = '{ID_CORR1, ID_CORR2, ID_CORR3, ID_CORR4,
                                 ID_GPS_EPH, ID_BDS_EPH};

  // Receiver state as the predictor sees it
  logic [LEN_W-1:0] max_len_cfg = MAX_LEN_RESET;
  logic [23:0]      sync_win    = '0;
  logic [LEN_W-1:0] sync_cnt    = '0;
  logic [LEN_W-1:0] frame_len   = '0;
  logic [31:0]      crc_acc     = '0;
  logic [31:0]      crc_rx      = '0;
  logic [15:0]      hid         = '0;
  logic [7:0]       hts         = '0;
  logic [15:0]      hwk         = '0;
  logic [31:0]      htow        = '0;

  // Reflected CRC-32, one data byte per call, shifted in a bit at a time
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [2:0] id_class(input logic [15:0] id);
    if (id == ID_CORR1) return CLS_CORR1;
    if (id == ID_CORR2) return CLS_CORR2;
    if (id == ID_CORR3) return CLS_CORR3;
    if (id == ID_CORR4) return CLS_CORR4;
    if (id == ID_GPS_EPH) return CLS_GPS_EPH;
    if (id == ID_BDS_EPH) return CLS_BDS_EPH;
    return CLS_OTHER;
  endfunction

  // Advance the receiver by one byte; returns 1 when the byte closes a frame
  function automatic bit track_byte(input logic [7:0] b, output frame_rpt_t r);
    logic [LEN_W-1:0] idx;
    logic [1:0]       lane;
    r = '0;
    idx = sync_cnt;
    if (idx == '0) begin
      sync_win = {sync_win[15:0], b};
      if (sync_win == {PRE0, PRE1, PRE2}) begin
        sync_cnt  = 17'd3;
        crc_acc   = crc32_step(crc32_step(crc32_step(32'd0, PRE0), PRE1), PRE2);
        crc_rx    = '0;
        frame_len = '0;
        hid       = '0;
        hts       = '0;
        hwk       = '0;
        htow      = '0;
      end
      return 1'b0;
    end

    if (idx < 17'd8 || idx < frame_len) begin
      crc_acc = crc32_step(crc_acc, b);
    end else begin
      lane = 2'(idx - frame_len);
      crc_rx = crc_rx | (32'(b) << (8 * lane));
    end

    case (idx)
      17'd4:  hid[7:0] = b;
      17'd5:  hid[15:8] = b;
      17'd6:  frame_len = 17'(b);
      17'd7:  frame_len = 17'({b, frame_len[7:0]}) + HDR_LEN;
      17'd9:  hts = b;
      17'd10: hwk[7:0] = b;
      17'd11: hwk[15:8] = b;
      17'd12, 17'd13, 17'd14, 17'd15: htow[8 * (int'(idx) - 12) +: 8] = b;
      default: ;
    endcase

    if (idx == 17'd7 && frame_len > max_len_cfg) begin
      sync_cnt = '0;
      r.status = ST_LEN_ERR;
      r.id     = hid;
      r.cls    = id_class(hid);
      r.len    = frame_len;
      return 1'b1;
    end

    sync_cnt = idx + 17'd1;
    if (sync_cnt < 17'd8 || int'(sync_cnt) < int'(frame_len) + 4) return 1'b0;

    sync_cnt = '0;
    if (crc_acc != crc_rx) r.status = ST_CRC_ERR;
    else if (hts == BAD_TIME_STATUS || hwk == 16'd0) r.status = ST_BAD_TIME;
    else r.status = ST_OK;
    r.id  = hid;
    r.cls = id_class(hid);
    r.len = frame_len;
    r.ts  = hts;
    r.wk  = hwk;
    r.tow = htow;
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_cnt++;
  endtask

  // Random bytes that never complete a preamble; partial preambles are mixed in
  task automatic add_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: push_byte(PRE0);
        1: begin
          push_byte(PRE0);
          push_byte(PRE1);
        end
        default: begin
          b = 8'($urandom);
          if (b == PRE2) b = 8'hB4;
          push_byte(b);
        end
      endcase
    end
  endtask

  // Queue one frame. corrupt: 1 flips a CRC byte, 2 flips a body byte after the
  // CRC is taken. cut > 0 stops the frame after that many bytes. A frame that the
  // current limit rejects is sent only up to its length bytes.
  task automatic add_frame(input logic [15:0] id, input int plen, input logic [7:0] ts,
                           input logic [15:0] wk, input logic [31:0] tow,
                           input int corrupt, input int cut);
    logic [7:0]  fb[$];
    logic [31:0] c;
    int          n;
    fb = {PRE0, PRE1, PRE2, 8'($urandom), id[7:0], id[15:8], 8'(plen), 8'(plen >> 8),
          8'($urandom), ts, wk[7:0], wk[15:8], tow[7:0], tow[15:8], tow[23:16],
          tow[31:24]};
    repeat (8 + plen) fb.push_back(8'($urandom));
    c = 32'd0;
    foreach (fb[i]) c = crc32_step(c, fb[i]);
    if (corrupt == 2) fb[$urandom_range(16, fb.size() - 1)] ^= 8'($urandom_range(1, 255));
    for (int k = 0; k < 4; k++) fb.push_back(c[8 * k +: 8]);
    if (corrupt == 1) fb[fb.size() - 1 - $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    n = fb.size();
    if (plen + 24 > int'(max_len_cfg)) n = 8;
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) push_byte(fb[i]);
  endtask

  // Hold until every queued byte is taken and every report has come back
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len_cfg = v;
  endtask

  // Byte driver
  always @(posedge clk) begin : drive_bytes
    frame_rpt_t rpt;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_cnt++;
        if (track_byte(in_ch.data_byte, rpt)) pending_reports.push_back(rpt);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= tx_bytes.pop_front();
          if (src_gap_pct > 0 && $urandom_range(1, 100) <= src_gap_pct)
            gap_left = $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin : check_reports
    frame_rpt_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $error("frame report with no frame pending");
          fail_count++;
        end else begin
          exp_r = pending_reports.pop_front();
          if (out_ch.frame_status !== exp_r.status) begin
            $error("frame_status: expected %0d, got %0d", exp_r.status, out_ch.frame_status);
            fail_count++;
          end
          if (out_ch.message_id !== exp_r.id) begin
            $error("message_id: expected %0d, got %0d", exp_r.id, out_ch.message_id);
            fail_count++;
          end
          if (out_ch.message_class !== exp_r.cls) begin
            $error("message_class: expected %0d, got %0d", exp_r.cls, out_ch.message_class);
            fail_count++;
          end
          if (out_ch.frame_length !== exp_r.len) begin
            $error("frame_length: expected %0d, got %0d", exp_r.len, out_ch.frame_length);
            fail_count++;
          end
          if (out_ch.time_status !== exp_r.ts) begin
            $error("time_status: expected %0d, got %0d", exp_r.ts, out_ch.time_status);
            fail_count++;
          end
          if (out_ch.week_number !== exp_r.wk) begin
            $error("week_number: expected %0d, got %0d", exp_r.wk, out_ch.week_number);
            fail_count++;
          end
          if (out_ch.tow_ms !== exp_r.tow) begin
            $error("tow_ms: expected %0d, got %0d", exp_r.tow, out_ch.tow_ms);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_stall_pct > 0 && $urandom_range(1, 100) <= sink_stall_pct)
          stall_left = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_receiver_frame_sync_crc_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int          gap_pct [6];
    int          stall_pct [6];
    int          used;
    int          pick;
    int          plen;
    int          lo;
    int unsigned mark;
    logic [15:0] id;
    logic [7:0]  ts;
    logic [15:0] wk;

    gap_pct   = '{10, 30, 0, 20, 5, 0};
    stall_pct = '{20, 0, 30, 10, 40, 0};

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset limit
    src_gap_pct    = 15;
    sink_stall_pct = 15;
    add_noise(5);
    add_frame(ID_CORR1, 0, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
    add_frame(ID_CORR2, 1, 8'hFF, 16'd1, 32'd0, 0, 0);
    add_frame(ID_CORR3, 3, 8'd7, 16'd2300, $urandom, 0, 0);
    add_frame(ID_CORR4, 8, 8'd7, 16'd2301, $urandom, 0, 0);
    add_frame(ID_GPS_EPH, 2, 8'd180, 16'd2302, $urandom, 0, 0);
    add_frame(ID_BDS_EPH, 5, 8'd180, 16'd2303, $urandom, 0, 0);
    add_frame(16'd0, 0, 8'd1, 16'd2304, $urandom, 0, 0);
    add_frame(16'hFFFF, 4, 8'd1, 16'd2305, $urandom, 0, 0);
    add_frame(16'd500, 6, 8'd3, 16'd2300, $urandom, 1, 0);
    add_frame(ID_CORR1, 10, 8'd3, 16'd2300, $urandom, 2, 0);
    add_frame(ID_CORR2, 2, BAD_TIME_STATUS, 16'd2300, $urandom, 0, 0);
    add_frame(ID_GPS_EPH, 2, 8'd20, 16'd0, $urandom, 0, 0);
    // CRC mismatch wins over bad time
    add_frame(ID_BDS_EPH, 1, BAD_TIME_STATUS, 16'd0, $urandom, 1, 0);
    add_frame(16'hFFFF, 65535, 8'd1, 16'd9, $urandom, 0, 0);
    add_frame(ID_CORR3, 16357, 8'd1, 16'd9, $urandom, 0, 0);
    // Broken frame swallows the start of the next one
    add_frame(ID_CORR4, 3, 8'd5, 16'd77, $urandom, 0, 12);
    add_frame(ID_CORR1, 0, 8'd5, 16'd77, $urandom, 0, 0);
    add_noise(10);
    add_frame(ID_CORR2, 0, 8'd5, 16'd78, $urandom, 0, 0);

    // Limit at one bare header, then below a header
    write_max_len(HDR_LEN);
    add_frame(ID_CORR2, 0, 8'd2, 16'd100, $urandom, 0, 0);
    add_frame(ID_CORR2, 1, 8'd2, 16'd100, $urandom, 0, 0);
    write_max_len('0);
    add_frame(ID_GPS_EPH, 0, 8'd2, 16'd100, $urandom, 0, 0);
    write_max_len(HDR_LEN - 17'd1);
    add_frame(ID_BDS_EPH, 0, 8'd2, 16'd100, $urandom, 0, 0);

    // Frame length right at the limit
    write_max_len(17'd60);
    add_frame(ID_BDS_EPH, 36, 8'd9, 16'd2400, $urandom, 0, 0);

    // Random phases under several limits
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_max_len(17'($urandom_range(24, 60)));
        1:       write_max_len(17'h1FFFF);
        2:       write_max_len(17'($urandom_range(0, 23)));
        3:       write_max_len(MAX_LEN_RESET);
        4:       write_max_len(17'($urandom_range(61, 400)));
        default: write_max_len(17'($urandom_range(24, 40)));
      endcase
      src_gap_pct    = gap_pct[ph];
      sink_stall_pct = stall_pct[ph];
      used = 0;
      while (used < 180) begin
        mark = queued_cnt;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        id   = ($urandom_range(0, 9) < 4) ? known_ids[$urandom_range(0, 5)] : 16'($urandom);
        ts   = ($urandom_range(0, 9) == 0) ? BAD_TIME_STATUS : 8'($urandom);
        wk   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        if (pick < 10) begin
          add_noise($urandom_range(1, 12));
        end else begin
          if (pick < 20 && max_len_cfg < 17'd65559) begin
            lo = (max_len_cfg < HDR_LEN) ? 0 : int'(max_len_cfg) - 23;
            add_frame(id, $urandom_range(lo, 65535), ts, wk, $urandom, 0, 0);
          end else if (pick < 30) begin
            add_frame(id, plen, ts, wk, $urandom, 0, $urandom_range(8, plen + 27));
          end else if (pick < 45) begin
            add_frame(id, plen, ts, wk, $urandom, (pick < 38) ? 1 : 2, 0);
          end else begin
            add_frame(id, plen, ts, wk, $urandom, 0, 0);
          end
          used += int'(queued_cnt - mark);
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("binary_receiver_frame_sync_crc_top regression: pass");
    end else begin
      $display("binary_receiver_frame_sync_crc_top regression: fail");
    end
    $finish;
  end

endmodule
